// ===== sv/sade_pkg.sv =====
// Package for the duplicate-key sorter: widths, defaults, FSM states and cell control.
// No dependencies; used by sade_cell and sort_and_emit_duplicate_keys.
`default_nettype none
package sade_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 10;
  localparam int KEY_W        = 64;
  localparam int IO_ID_W      = 10;
  localparam int DATA_W       = 80;
  localparam int USER_W       = 3;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/sade_cell.sv =====
// One slot of the insertion chain: holds a key and an identifier.
// Shifts right on a sorted insert, left on a pop. Depends on sade_pkg.
`default_nettype none
module sade_cell #(
  parameter int ID_BITS = sade_pkg::ID_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire sade_pkg::cell_ctrl_t ctrl_i,
  input  wire sade_pkg::key_t      new_key_i,
  input  wire [ID_BITS-1:0]        new_id_i,
  input  wire                      valid_i,
  input  wire                      gt_left_i,
  input  wire sade_pkg::key_t      left_key_i,
  input  wire [ID_BITS-1:0]        left_id_i,
  input  wire sade_pkg::key_t      right_key_i,
  input  wire [ID_BITS-1:0]        right_id_i,
  output sade_pkg::key_t           key_o,
  output logic [ID_BITS-1:0]       id_o,
  output logic                     gt_o
);

  sade_pkg::key_t     key_q, key_d;
  logic [ID_BITS-1:0] id_q, id_d;

  // empty slots count as greater than any key
  assign gt_o  = !valid_i || (key_q > new_key_i);
  assign key_o = key_q;
  assign id_o  = id_q;

  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    if (ctrl_i.insert && gt_o) begin
      if (gt_left_i) begin
        key_d = left_key_i;
        id_d  = left_id_i;
      end else begin
        key_d = new_key_i;
        id_d  = new_id_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
      id_d  = right_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

endmodule
`default_nettype wire

// ===== sv/sort_and_emit_duplicate_keys.sv =====
// Channel  Dir  tdata                            tuser                        tlast
// s_axis   in   [9:0] id, [73:10] key, 0 pad     -                            last record
// m_axis   out  [9:0] id, [73:10] key, 0 pad     [0] first [1] found [2] ovf  last result
//
// Loading takes one word per cycle: each word is placed by one compare in every cell.
// After the last word, the chain pops its cells, CAPACITY at most, one per cycle while
// m_axis is not stalled, then issues the closing word; s_axis is not ready meanwhile.
// Reset clears the fill count, flags and FSM; cell contents are left as they are.
// A stalled m_axis freezes the drain; the output register holds its word.
// Depends on sade_pkg and sade_cell.
`default_nettype none
module sort_and_emit_duplicate_keys #(
  parameter int CAPACITY = sade_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = sade_pkg::ID_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [sade_pkg::DATA_W-1:0]   s_axis_tdata,  // record_id, record_key
  input  wire                          s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [sade_pkg::DATA_W-1:0]  m_axis_tdata,  // out_id, out_key
  output logic [sade_pkg::USER_W-1:0]  m_axis_tuser,  // group_first, found, overflowed
  output logic                         m_axis_tlast
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IoW  = sade_pkg::IO_ID_W;
  localparam int KeyW = sade_pkg::KEY_W;

  sade_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 prev_v_q, prev_v_d;
  sade_pkg::key_t       prev_key_q, prev_key_d;
  logic                 hold_v_q, hold_v_d;
  logic                 hold_first_q, hold_first_d;
  sade_pkg::key_t       hold_key_q, hold_key_d;
  logic [ID_BITS-1:0]   hold_id_q, hold_id_d;
  logic                 mv_q, mv_d;
  logic [IoW-1:0]       mid_q, mid_d;
  sade_pkg::key_t       mkey_q, mkey_d;
  logic                 mfirst_q, mfirst_d, mfound_q, mfound_d;
  logic                 movf_q, movf_d, mlast_q, mlast_d;

  sade_pkg::cell_ctrl_t ctrl;
  sade_pkg::key_t       new_key;
  logic [ID_BITS-1:0]   new_id;
  sade_pkg::key_t       cell_key [CAPACITY];
  logic [ID_BITS-1:0]   cell_id  [CAPACITY];
  logic [CAPACITY-1:0]  cell_gt;
  logic                 s_acc, out_ok, dup, prev_eq;

  assign new_key = s_axis_tdata[IoW +: KeyW];
  assign new_id  = ID_BITS'(s_axis_tdata[IoW-1:0]);
  assign s_axis_tready = (state_q == sade_pkg::ST_LOAD);
  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign out_ok = !mv_q || m_axis_tready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sade_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_key_i  (new_key),
      .new_id_i   (new_id),
      .valid_i    (count_q > CntW'(i)),
      .gt_left_i  ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i-1]),
      .left_key_i (cell_key[(i == 0) ? 0 : i-1]),
      .left_id_i  (cell_id[(i == 0) ? 0 : i-1]),
      .right_key_i(cell_key[(i == CAPACITY-1) ? i : i+1]),
      .right_id_i (cell_id[(i == CAPACITY-1) ? i : i+1]),
      .key_o      (cell_key[i]),
      .id_o       (cell_id[i]),
      .gt_o       (cell_gt[i])
    );
  end

  assign prev_eq = prev_v_q && (prev_key_q == cell_key[0]);
  assign dup     = prev_eq || ((count_q > CntW'(1)) && (cell_key[1] == cell_key[0]));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    prev_v_d     = prev_v_q;
    prev_key_d   = prev_key_q;
    hold_v_d     = hold_v_q;
    hold_first_d = hold_first_q;
    hold_key_d   = hold_key_q;
    hold_id_d    = hold_id_q;
    mv_d         = mv_q && !m_axis_tready;
    mid_d        = mid_q;
    mkey_d       = mkey_q;
    mfirst_d     = mfirst_q;
    mfound_d     = mfound_q;
    movf_d       = movf_q;
    mlast_d      = mlast_q;
    ctrl         = '0;

    case (state_q)
      sade_pkg::ST_LOAD: begin
        if (s_acc) begin
          if (count_q < CntW'(CAPACITY)) begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d  = sade_pkg::ST_DRAIN;
            prev_v_d = 1'b0;
            hold_v_d = 1'b0;
          end
        end
      end
      sade_pkg::ST_DRAIN: begin
        if (out_ok) begin
          if (count_q != '0) begin
            ctrl.pop   = 1'b1;
            count_d    = count_q - CntW'(1);
            prev_v_d   = 1'b1;
            prev_key_d = cell_key[0];
            if (dup) begin
              if (hold_v_q) begin
                mv_d     = 1'b1;
                mid_d    = IoW'(hold_id_q);
                mkey_d   = hold_key_q;
                mfirst_d = hold_first_q;
                mfound_d = 1'b1;
                movf_d   = ovf_q;
                mlast_d  = 1'b0;
              end
              hold_v_d     = 1'b1;
              hold_first_d = !prev_eq;
              hold_key_d   = cell_key[0];
              hold_id_d    = cell_id[0];
            end
          end else begin
            // closing word: held record marked last, or the no-duplicate word
            mv_d     = 1'b1;
            mid_d    = hold_v_q ? IoW'(hold_id_q) : '0;
            mkey_d   = hold_v_q ? hold_key_q : '0;
            mfirst_d = hold_v_q && hold_first_q;
            mfound_d = hold_v_q;
            movf_d   = ovf_q;
            mlast_d  = 1'b1;
            hold_v_d = 1'b0;
            prev_v_d = 1'b0;
            ovf_d    = 1'b0;
            state_d  = sade_pkg::ST_LOAD;
          end
        end
      end
      default: state_d = sade_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sade_pkg::ST_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      prev_v_q <= 1'b0;
      hold_v_q <= 1'b0;
      mv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      prev_v_q <= prev_v_d;
      hold_v_q <= hold_v_d;
      mv_q     <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_key_q   <= prev_key_d;
    hold_first_q <= hold_first_d;
    hold_key_q   <= hold_key_d;
    hold_id_q    <= hold_id_d;
    mid_q        <= mid_d;
    mkey_q       <= mkey_d;
    mfirst_q     <= mfirst_d;
    mfound_q     <= mfound_d;
    movf_q       <= movf_d;
    mlast_q      <= mlast_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {{(sade_pkg::DATA_W - IoW - KeyW){1'b0}}, mkey_q, mid_q};
  assign m_axis_tuser  = {movf_q, mfound_q, mfirst_q};
  assign m_axis_tlast  = mlast_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sade_pkg::ST_LOAD |-> !hold_v_q)
    else $error("held record left over while loading");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sade_pkg::ST_DRAIN && count_q == '0 && out_ok
    |=> m_axis_tvalid && m_axis_tlast && state_q == sade_pkg::ST_LOAD)
    else $error("drain end did not issue the closing word");

  a_found_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("no-duplicate word malformed");
`endif

endmodule
`default_nettype wire
